FILE: sv/dam_pkg.sv
// ----------------------------------------------------------------------------
// DRAM address mapper package
// Shared types, register indexes and codes for the address mapper.
// ----------------------------------------------------------------------------
package dam_pkg;

	// Config port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 5;

	// Bit-position width: covers every field offset the mapper can form
	localparam int POS_W = 7;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAPPING_MODE   = 3'd0,
		REG_MOP_LOG2       = 3'd1,
		REG_PERMUTE_ENABLE = 3'd2,
		REG_CHANNEL_BITS   = 3'd3,
		REG_BANKGROUP_BITS = 3'd4,
		REG_BANK_BITS      = 3'd5,
		REG_COLUMN_BITS    = 3'd6,
		REG_CACHE_SET_BITS = 3'd7
	} reg_idx_t;

	// Layout codes
	localparam logic MAP_MOP = 1'b0;
	localparam logic MAP_ZEN = 1'b1;

	// Request codes
	localparam logic REQ_DECODE  = 1'b0;
	localparam logic REQ_REWRITE = 1'b1;

	typedef struct packed {
		logic       mapping_mode;
		logic [3:0] mop_log2;
		logic       permute_enable;
		logic [2:0] channel_bits;
		logic [2:0] bankgroup_bits;
		logic [2:0] bank_bits;
		logic [3:0] column_bits;
		logic [4:0] cache_set_bits;
	} cfg_t;

	typedef struct packed {
		logic        req_type;
		logic [63:0] address;
		logic [7:0]  new_bank_index;
	} req_t;

	typedef struct packed {
		logic [3:0]  channel;
		logic [3:0]  bankgroup;
		logic [3:0]  bank;
		logic [15:0] row;
		logic [7:0]  flat_bank;
		logic [63:0] rewritten_address;
	} rsp_t;

	// Low mask of w ones, w up to 7
	function automatic logic [7:0] low_mask8(input logic [2:0] w);
		logic [8:0] one;
		one = 9'd1 << w;
		return 8'(one - 9'd1);
	endfunction

	// Low mask of w ones, w up to 14
	function automatic logic [15:0] low_mask16(input logic [3:0] w);
		logic [16:0] one;
		one = 17'd1 << w;
		return 16'(one - 17'd1);
	endfunction

endpackage

FILE: sv/dam_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one mapping request word.
// ----------------------------------------------------------------------------
interface dam_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [63:0] address;
	logic [7:0]  new_bank_index;

	modport source (output valid, output req_type, output address, output new_bank_index,
		input ready);
	modport sink (input valid, input req_type, input address, input new_bank_index,
		output ready);
endinterface

FILE: sv/dam_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one decoded result word.
// ----------------------------------------------------------------------------
interface dam_rsp_if;
	logic        valid;
	logic        ready;
	logic [3:0]  channel;
	logic [3:0]  bankgroup;
	logic [3:0]  bank;
	logic [15:0] row;
	logic [7:0]  flat_bank;
	logic [63:0] rewritten_address;

	modport source (output valid, output channel, output bankgroup, output bank, output row,
		output flat_bank, output rewritten_address, input ready);
	modport sink (input valid, input channel, input bankgroup, input bank, input row,
		input flat_bank, input rewritten_address, output ready);
endinterface

FILE: sv/dam_cfg_regs.sv
// ----------------------------------------------------------------------------
// Mapper configuration registers
// Write-only register file holding the layout settings.
// ----------------------------------------------------------------------------
module dam_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [dam_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dam_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output dam_pkg::cfg_t                cfg
);

	dam_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mapping_mode   <= dam_pkg::MAP_MOP;
			cfg_q.mop_log2       <= 4'd2;
			cfg_q.permute_enable <= 1'b0;
			cfg_q.channel_bits   <= 3'd1;
			cfg_q.bankgroup_bits <= 3'd2;
			cfg_q.bank_bits      <= 3'd2;
			cfg_q.column_bits    <= 4'd7;
			cfg_q.cache_set_bits <= 5'd11;
		end else if (cfg_we) begin
			case (cfg_index)
				dam_pkg::REG_MAPPING_MODE:   cfg_q.mapping_mode   <= cfg_wdata[0];
				dam_pkg::REG_MOP_LOG2:       cfg_q.mop_log2       <= cfg_wdata[3:0];
				dam_pkg::REG_PERMUTE_ENABLE: cfg_q.permute_enable <= cfg_wdata[0];
				dam_pkg::REG_CHANNEL_BITS:   cfg_q.channel_bits   <= cfg_wdata[2:0];
				dam_pkg::REG_BANKGROUP_BITS: cfg_q.bankgroup_bits <= cfg_wdata[2:0];
				dam_pkg::REG_BANK_BITS:      cfg_q.bank_bits      <= cfg_wdata[2:0];
				dam_pkg::REG_COLUMN_BITS:    cfg_q.column_bits    <= cfg_wdata[3:0];
				dam_pkg::REG_CACHE_SET_BITS: cfg_q.cache_set_bits <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: sv/dam_map_logic.sv
// ----------------------------------------------------------------------------
// Mapper datapath
// Field offsets, bit extraction, bank permutation and bank rewrite.
// ----------------------------------------------------------------------------
module dam_map_logic #(
	parameter int BLOCK_OFFSET_BITS = 6,
	parameter int ROW_BITS          = 16
) (
	input  dam_pkg::cfg_t cfg,
	input  dam_pkg::req_t req,
	output dam_pkg::rsp_t rsp
);

	localparam logic [dam_pkg::POS_W-1:0] BLK = dam_pkg::POS_W'(BLOCK_OFFSET_BITS);
	localparam logic [63:0] ROW_MASK = (64'd1 << ROW_BITS) - 64'd1;

	logic [dam_pkg::POS_W-1:0] ch_pos, bg_pos, ba_pos, row_pos, perm_pos, permb_pos;
	logic [63:0] ch_sh, bg_sh, ba_sh, row_sh, pbg_sh, pba_sh;
	logic [7:0]  ch_v, bg_v, ba_v, flat_sh;
	logic [63:0] row_v;
	logic [3:0]  n_bits;
	logic [15:0] n_mask;
	logic [63:0] clr_mask, ins_bits;

	always_comb begin
		case (cfg.mapping_mode)
			dam_pkg::MAP_MOP: begin
				ch_pos = dam_pkg::POS_W'(cfg.mop_log2);
				bg_pos = dam_pkg::POS_W'(cfg.mop_log2) + dam_pkg::POS_W'(cfg.channel_bits);
			end
			dam_pkg::MAP_ZEN: begin
				ch_pos = '0;
				bg_pos = dam_pkg::POS_W'(cfg.channel_bits) + dam_pkg::POS_W'(1);
			end
			default: begin
				ch_pos = '0;
				bg_pos = '0;
			end
		endcase
		ba_pos  = bg_pos + dam_pkg::POS_W'(cfg.bankgroup_bits);
		row_pos = dam_pkg::POS_W'(cfg.channel_bits) + dam_pkg::POS_W'(cfg.bankgroup_bits)
			+ dam_pkg::POS_W'(cfg.bank_bits) + dam_pkg::POS_W'(cfg.column_bits);
		perm_pos  = dam_pkg::POS_W'(cfg.cache_set_bits) + BLK;
		permb_pos = perm_pos + dam_pkg::POS_W'(cfg.bankgroup_bits);
	end

	// Shifts by 64 or more yield zero, so out-of-range fields read as 0
	assign ch_sh  = req.address >> (ch_pos + BLK);
	assign bg_sh  = req.address >> (bg_pos + BLK);
	assign ba_sh  = req.address >> (ba_pos + BLK);
	assign row_sh = req.address >> (row_pos + BLK);
	assign pbg_sh = req.address >> perm_pos;
	assign pba_sh = req.address >> permb_pos;

	always_comb begin
		ch_v = ch_sh[7:0] & dam_pkg::low_mask8(cfg.channel_bits);
		bg_v = bg_sh[7:0] & dam_pkg::low_mask8(cfg.bankgroup_bits);
		ba_v = ba_sh[7:0] & dam_pkg::low_mask8(cfg.bank_bits);
		if (cfg.permute_enable) begin
			bg_v = bg_v ^ (pbg_sh[7:0] & dam_pkg::low_mask8(cfg.bankgroup_bits));
			ba_v = ba_v ^ (pba_sh[7:0] & dam_pkg::low_mask8(cfg.bank_bits));
		end
		row_v   = row_sh & ROW_MASK;
		flat_sh = bg_v << cfg.bank_bits;
	end

	// Rewrite: bank group and bank field starts at the bank group offset
	assign n_bits   = 4'(cfg.bankgroup_bits) + 4'(cfg.bank_bits);
	assign n_mask   = dam_pkg::low_mask16(n_bits);
	assign clr_mask = {48'd0, n_mask} << (bg_pos + BLK);
	assign ins_bits = {56'd0, req.new_bank_index & n_mask[7:0]} << (bg_pos + BLK);

	always_comb begin
		rsp.channel   = ch_v[3:0];
		rsp.bankgroup = bg_v[3:0];
		rsp.bank      = ba_v[3:0];
		rsp.row       = row_v[15:0];
		rsp.flat_bank = flat_sh + ba_v;
		if (req.req_type == dam_pkg::REQ_REWRITE) begin
			rsp.rewritten_address = (req.address & ~clr_mask) | ins_bits;
		end else begin
			rsp.rewritten_address = '0;
		end
	end

endmodule

FILE: sv/dram_address_mapper_core.sv
// ----------------------------------------------------------------------------
// DRAM address mapper core
// Maps physical addresses to channel, bank group, bank and row, and
// rewrites the bank index of an address on request.
// ----------------------------------------------------------------------------
//  port       | dir | handshake    | word
//  -----------+-----+--------------+--------------------------------------
//  req        | in  | valid/ready  | req_type, address, new_bank_index
//  rsp        | out | valid/ready  | channel, bankgroup, bank, row,
//             |     |              | flat_bank, rewritten_address
//  cfg_*      | in  | write enable | register index, write data
//
//  One word in and one word out per cycle while rsp.ready is high. A word
//  passes the request register, then the map logic into the response register.
//  Reset clears the valid flags and loads the register defaults; no
//  clearing pass. A stalled response holds its word while the request
//  stage keeps filling; req.ready falls only when both stages are full
//  and rsp.ready is low.
// ----------------------------------------------------------------------------
module dram_address_mapper_core #(
	parameter int BLOCK_OFFSET_BITS = 6,
	parameter int ROW_BITS          = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	dam_req_if.sink                        req,
	dam_rsp_if.source                      rsp,
	input  logic                           cfg_we,
	input  logic [dam_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dam_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	dam_pkg::cfg_t cfg;
	dam_pkg::req_t req_s1;
	dam_pkg::rsp_t map_rsp;
	dam_pkg::rsp_t rsp_s2;
	logic          valid_s1;
	logic          valid_s2;
	logic          advance;

	// Register file
	dam_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Output stage moves when empty or drained this cycle
	assign advance   = !valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || advance;

	// Stage 1: request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.req_type       <= req.req_type;
			req_s1.address        <= req.address;
			req_s1.new_bank_index <= req.new_bank_index;
		end
	end

	// Field extraction, permutation, rewrite
	dam_map_logic #(
		.BLOCK_OFFSET_BITS (BLOCK_OFFSET_BITS),
		.ROW_BITS          (ROW_BITS)
	) u_map (
		.cfg (cfg),
		.req (req_s1),
		.rsp (map_rsp)
	);

	// Stage 2: response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_s2 <= map_rsp;
		end
	end

	assign rsp.valid             = valid_s2;
	assign rsp.channel           = rsp_s2.channel;
	assign rsp.bankgroup         = rsp_s2.bankgroup;
	assign rsp.bank              = rsp_s2.bank;
	assign rsp.row               = rsp_s2.row;
	assign rsp.flat_bank         = rsp_s2.flat_bank;
	assign rsp.rewritten_address = rsp_s2.rewritten_address;

endmodule

FILE: sv/dam_checker.sv
// ----------------------------------------------------------------------------
// Mapper port checker
// Port-level timing checks on the mapper core, attached by bind.
// ----------------------------------------------------------------------------
module dam_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        req_type,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [63:0] rsp_rewritten_address
);

	// Empty output side never back-pressures the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("req not ready with empty output");

	// Accepted word reaches the output through both stages when not stalled
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) ##1 (rsp_ready || !rsp_valid) |=> rsp_valid)
		else $error("accepted word did not arrive");

	// Decode requests return a zero rewritten address
	a_decode_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req_type == dam_pkg::REQ_DECODE)
		##1 (rsp_ready || !rsp_valid) |=> rsp_rewritten_address == 64'd0)
		else $error("decode word carries a rewritten address");

	// Stalled response holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rewritten_address))
		else $error("stalled response changed");

endmodule

bind dram_address_mapper_core dam_checker u_dam_checker (
	.clk                   (clk),
	.arst_n                (arst_n),
	.req_valid             (req.valid),
	.req_ready             (req.ready),
	.req_type              (req.req_type),
	.rsp_valid             (rsp.valid),
	.rsp_ready             (rsp.ready),
	.rsp_rewritten_address (rsp.rewritten_address)
);

FILE: bench/dram_address_mapper_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DRAM address mapper core testbench
// Sends decode and rewrite requests through the valid/ready channels under
// a range of layouts and field widths and checks every response word
// against a local prediction of the address map.
// ----------------------------------------------------------------------------
module dram_address_mapper_core_tb;

	localparam int BLK        = 6;       // cache-block offset bits
	localparam int ROW_W      = 16;      // row field width
	localparam int N_PHASES   = 14;      // layout phases, first two pinned
	localparam int PHASE_REQS = 75;      // requests per setting
	localparam int SETTLE     = 6;       // cycles waited after drain
	localparam int LIMIT      = 200000;  // cycle budget for the whole run

	logic clk;
	logic arst_n;
	logic                           cfg_we;
	logic [dam_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [dam_pkg::CFG_DATA_W-1:0] cfg_wdata;

	dam_req_if req_ch ();
	dam_rsp_if rsp_ch ();

	dram_address_mapper_core #(
		.BLOCK_OFFSET_BITS(BLK),
		.ROW_BITS         (ROW_W)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Local copy of the mapper registers, tracked as they are written
	dam_pkg::cfg_t map_cfg;

	dam_pkg::req_t pending_reqs[$];    // requests not yet offered to the block
	dam_pkg::rsp_t predicted_maps[$];  // predicted words, oldest first
	int   errors;
	int   cycles;
	int   src_idle_pct;
	int   snk_idle_pct;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------
	function automatic logic [63:0] ones(input int unsigned w);
		return (w >= 64) ? {64{1'b1}} : (64'd1 << w) - 64'd1;
	endfunction

	// Bits at or above position 64 read as zero
	function automatic logic [63:0] slice(input logic [63:0] a, input int unsigned pos,
			input int unsigned w);
		return (pos >= 64) ? 64'd0 : ((a >> pos) & ones(w));
	endfunction

	function automatic dam_pkg::rsp_t map_address(input dam_pkg::cfg_t c,
			input dam_pkg::req_t r);
		int unsigned ch_pos, bg_pos, ba_pos, row_pos, perm_pos, n, pos;
		logic [63:0] ch, bg, ba, rw, flat, res;
		dam_pkg::rsp_t m;
		if (c.mapping_mode == dam_pkg::MAP_MOP) begin
			ch_pos = 32'(c.mop_log2);
			bg_pos = ch_pos + 32'(c.channel_bits);
		end else begin
			// zen: channel at block bit 0, bank group one bit above the channel field
			ch_pos = 0;
			bg_pos = 32'(c.channel_bits) + 1;
		end
		ba_pos   = bg_pos + 32'(c.bankgroup_bits);
		row_pos  = 32'(c.channel_bits) + 32'(c.bankgroup_bits) + 32'(c.bank_bits)
			+ 32'(c.column_bits);
		perm_pos = 32'(c.cache_set_bits) + BLK;

		ch = slice(r.address, ch_pos + BLK, 32'(c.channel_bits));
		bg = slice(r.address, bg_pos + BLK, 32'(c.bankgroup_bits));
		ba = slice(r.address, ba_pos + BLK, 32'(c.bank_bits));
		if (c.permute_enable) begin
			bg = bg ^ slice(r.address, perm_pos, 32'(c.bankgroup_bits));
			ba = ba ^ slice(r.address, perm_pos + 32'(c.bankgroup_bits), 32'(c.bank_bits));
		end
		rw   = slice(r.address, row_pos + BLK, ROW_W);
		// flat index from the full-width values, cut afterwards
		flat = (bg << c.bank_bits) + ba;

		res = 64'd0;
		if (r.req_type == dam_pkg::REQ_REWRITE) begin
			n   = 32'(c.bankgroup_bits) + 32'(c.bank_bits);
			pos = bg_pos + BLK;
			res = r.address;
			if (pos < 64) begin
				res = res & ~(ones(n) << pos);
				res = res | ((64'(r.new_bank_index) & ones(n)) << pos);
			end
		end

		m.channel           = ch[3:0];
		m.bankgroup         = bg[3:0];
		m.bank              = ba[3:0];
		m.row               = rw[15:0];
		m.flat_bank         = flat[7:0];
		m.rewritten_address = res;
		return m;
	endfunction

	// ------------------------------------------------------------------
	// Error log: first ten printed, the rest only counted
	// ------------------------------------------------------------------
	task automatic flag(input string msg);
		errors++;
		if (errors <= 10)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	// ------------------------------------------------------------------
	// Clock and cycle budget
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("TIMEOUT after %0d cycles, %0d words outstanding", cycles,
				predicted_maps.size());
			$display("dram_address_mapper_core_tb: done, errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Request driver: offers the next backlog word, idling at random.
	// The prediction is taken at acceptance with the current registers;
	// registers only change while the block is drained.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		dam_pkg::req_t nxt;
		if (!arst_n) begin
			req_ch.valid          <= 1'b0;
			req_ch.req_type       <= dam_pkg::REQ_DECODE;
			req_ch.address        <= '0;
			req_ch.new_bank_index <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				predicted_maps.push_back(map_address(map_cfg,
					'{req_ch.req_type, req_ch.address, req_ch.new_bank_index}));
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
					nxt = pending_reqs.pop_front();
					req_ch.valid          <= 1'b1;
					req_ch.req_type       <= nxt.req_type;
					req_ch.address        <= nxt.address;
					req_ch.new_bank_index <= nxt.new_bank_index;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Response monitor: random backpressure, in-order field compare
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		dam_pkg::rsp_t got, want;
		string diffs;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = '{rsp_ch.channel, rsp_ch.bankgroup, rsp_ch.bank, rsp_ch.row,
					rsp_ch.flat_bank, rsp_ch.rewritten_address};
				if (predicted_maps.size() == 0) begin
					flag($sformatf("unexpected word ch=%0d bg=%0d ba=%0d row=%h flat=%h adr=%h",
						got.channel, got.bankgroup, got.bank, got.row, got.flat_bank,
						got.rewritten_address));
				end else begin
					want  = predicted_maps.pop_front();
					diffs = "";
					if (got.channel !== want.channel)     diffs = {diffs, " channel"};
					if (got.bankgroup !== want.bankgroup) diffs = {diffs, " bankgroup"};
					if (got.bank !== want.bank)           diffs = {diffs, " bank"};
					if (got.row !== want.row)             diffs = {diffs, " row"};
					if (got.flat_bank !== want.flat_bank) diffs = {diffs, " flat_bank"};
					if (got.rewritten_address !== want.rewritten_address)
						diffs = {diffs, " rewritten_address"};
					if (diffs != "")
						flag($sformatf({"mismatch in%s: exp ch=%0d bg=%0d ba=%0d row=%h ",
							"flat=%h adr=%h, got ch=%0d bg=%0d ba=%0d row=%h flat=%h adr=%h"},
							diffs, want.channel, want.bankgroup, want.bank, want.row,
							want.flat_bank, want.rewritten_address, got.channel,
							got.bankgroup, got.bank, got.row, got.flat_bank,
							got.rewritten_address));
				end
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Register writes, only while the block is drained
	// ------------------------------------------------------------------
	task automatic write_reg(input dam_pkg::reg_idx_t idx,
			input logic [dam_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			dam_pkg::REG_MAPPING_MODE:   map_cfg.mapping_mode   = val[0];
			dam_pkg::REG_MOP_LOG2:       map_cfg.mop_log2       = val[3:0];
			dam_pkg::REG_PERMUTE_ENABLE: map_cfg.permute_enable = val[0];
			dam_pkg::REG_CHANNEL_BITS:   map_cfg.channel_bits   = val[2:0];
			dam_pkg::REG_BANKGROUP_BITS: map_cfg.bankgroup_bits = val[2:0];
			dam_pkg::REG_BANK_BITS:      map_cfg.bank_bits      = val[2:0];
			dam_pkg::REG_COLUMN_BITS:    map_cfg.column_bits    = val[3:0];
			dam_pkg::REG_CACHE_SET_BITS: map_cfg.cache_set_bits = val[4:0];
			default: ;
		endcase
	endtask

	task automatic load_layout(input dam_pkg::cfg_t c);
		write_reg(dam_pkg::REG_MAPPING_MODE,   dam_pkg::CFG_DATA_W'(c.mapping_mode));
		write_reg(dam_pkg::REG_MOP_LOG2,       dam_pkg::CFG_DATA_W'(c.mop_log2));
		write_reg(dam_pkg::REG_PERMUTE_ENABLE, dam_pkg::CFG_DATA_W'(c.permute_enable));
		write_reg(dam_pkg::REG_CHANNEL_BITS,   dam_pkg::CFG_DATA_W'(c.channel_bits));
		write_reg(dam_pkg::REG_BANKGROUP_BITS, dam_pkg::CFG_DATA_W'(c.bankgroup_bits));
		write_reg(dam_pkg::REG_BANK_BITS,      dam_pkg::CFG_DATA_W'(c.bank_bits));
		write_reg(dam_pkg::REG_COLUMN_BITS,    dam_pkg::CFG_DATA_W'(c.column_bits));
		write_reg(dam_pkg::REG_CACHE_SET_BITS, dam_pkg::CFG_DATA_W'(c.cache_set_bits));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every queued request went in and every word came out
	task automatic drain();
		do @(posedge clk);
		while (pending_reqs.size() != 0 || req_ch.valid || predicted_maps.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send(input logic kind, input logic [63:0] adr, input logic [7:0] idx);
		pending_reqs.push_back('{kind, adr, idx});
	endtask

	// Mostly in-range widths, now and then a value past the documented range
	function automatic dam_pkg::cfg_t random_layout();
		dam_pkg::cfg_t c;
		c.mapping_mode   = 1'($urandom_range(0, 1));
		c.permute_enable = 1'($urandom_range(0, 1));
		c.mop_log2       = 4'(($urandom_range(0, 7) == 0) ? $urandom_range(13, 15)
			: $urandom_range(0, 12));
		c.channel_bits   = 3'(($urandom_range(0, 7) == 0) ? $urandom_range(5, 7)
			: $urandom_range(0, 4));
		c.bankgroup_bits = 3'(($urandom_range(0, 7) == 0) ? $urandom_range(5, 7)
			: $urandom_range(0, 4));
		c.bank_bits      = 3'(($urandom_range(0, 7) == 0) ? $urandom_range(5, 7)
			: $urandom_range(0, 4));
		c.column_bits    = 4'(($urandom_range(0, 7) == 0) ? 15 : $urandom_range(0, 14));
		c.cache_set_bits = 5'(($urandom_range(0, 7) == 0) ? $urandom_range(25, 31)
			: $urandom_range(0, 24));
		return c;
	endfunction

	// Address mix: dense random, sparse, one-hot, 48-bit, and the two extremes
	function automatic logic [63:0] random_address();
		logic [63:0] a;
		a = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0:       a = '0;
			1:       a = {64{1'b1}};
			2:       a = 64'd1 << $urandom_range(0, 63);
			3:       a = a & {$urandom, $urandom};
			4:       a = a & 64'h0000_FFFF_FFFF_FFFF;
			default: ;
		endcase
		return a;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		dam_pkg::cfg_t lay;
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = '0;
		cfg_wdata             = '0;
		req_ch.valid          = 1'b0;
		req_ch.req_type       = dam_pkg::REQ_DECODE;
		req_ch.address        = '0;
		req_ch.new_bank_index = '0;
		rsp_ch.ready          = 1'b0;
		errors                = 0;
		cycles                = 0;
		src_idle_pct          = 11;
		snk_idle_pct          = 64;
		// register defaults after reset
		map_cfg = '{mapping_mode: dam_pkg::MAP_MOP, mop_log2: 4'd2, permute_enable: 1'b0,
			channel_bits: 3'd1, bankgroup_bits: 3'd2, bank_bits: 3'd2,
			column_bits: 4'd7, cache_set_bits: 5'd11};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed: reset layout, extremes of address and index
		send(dam_pkg::REQ_DECODE,  64'h0, 8'h00);
		send(dam_pkg::REQ_DECODE,  {64{1'b1}}, 8'hFF);
		send(dam_pkg::REQ_REWRITE, {64{1'b1}}, 8'h00);
		send(dam_pkg::REQ_REWRITE, 64'h0, 8'hFF);
		send(dam_pkg::REQ_DECODE,  64'hAAAA_AAAA_AAAA_AAAA, 8'h55);
		send(dam_pkg::REQ_REWRITE, 64'h5555_5555_5555_5555, 8'hA5);
		send(dam_pkg::REQ_DECODE,  64'h8000_0000_0000_0000, 8'h01);
		drain();

		// --- directed: every register at its full width, so the decoded
		// values are wider than the output fields and get cut
		lay = '{mapping_mode: dam_pkg::MAP_MOP, mop_log2: 4'd15, permute_enable: 1'b1,
			channel_bits: 3'd7, bankgroup_bits: 3'd7, bank_bits: 3'd7,
			column_bits: 4'd15, cache_set_bits: 5'd31};
		load_layout(lay);
		send(dam_pkg::REQ_DECODE,  {64{1'b1}}, 8'h00);
		send(dam_pkg::REQ_DECODE,  64'hF0F0_F0F0_F0F0_F0F0, 8'h0F);
		send(dam_pkg::REQ_REWRITE, {64{1'b1}}, 8'h00);
		send(dam_pkg::REQ_REWRITE, 64'h0, 8'hFF);
		send(dam_pkg::REQ_DECODE,  64'h0123_4567_89AB_CDEF, 8'h80);
		drain();

		// --- directed: zen layout with permutation, top of the stated ranges
		lay = '{mapping_mode: dam_pkg::MAP_ZEN, mop_log2: 4'd12, permute_enable: 1'b1,
			channel_bits: 3'd4, bankgroup_bits: 3'd4, bank_bits: 3'd4,
			column_bits: 4'd14, cache_set_bits: 5'd24};
		load_layout(lay);
		send(dam_pkg::REQ_DECODE,  {64{1'b1}}, 8'h00);
		send(dam_pkg::REQ_REWRITE, 64'h0, 8'hFF);
		send(dam_pkg::REQ_DECODE,  64'h0123_4567_89AB_CDEF, 8'h00);
		send(dam_pkg::REQ_REWRITE, {64{1'b1}}, 8'h5A);
		drain();

		// --- directed: all widths zero; the rewrite field is empty and
		// the address must come back unchanged
		lay = '{mapping_mode: dam_pkg::MAP_MOP, mop_log2: 4'd0, permute_enable: 1'b1,
			channel_bits: 3'd0, bankgroup_bits: 3'd0, bank_bits: 3'd0,
			column_bits: 4'd0, cache_set_bits: 5'd0};
		load_layout(lay);
		send(dam_pkg::REQ_DECODE,  {64{1'b1}}, 8'hFF);
		send(dam_pkg::REQ_REWRITE, {64{1'b1}}, 8'hFF);
		send(dam_pkg::REQ_REWRITE, 64'hDEAD_BEEF_0BAD_F00D, 8'hFF);
		drain();

		// --- random: one layout per phase, idle pattern per third of the run
		for (int ph = 0; ph < N_PHASES; ph++) begin
			if (ph < N_PHASES / 3) begin
				src_idle_pct = 11;
				snk_idle_pct = 64;
			end else if (ph < 2 * N_PHASES / 3) begin
				src_idle_pct = 64;
				snk_idle_pct = 11;
			end else begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			lay = random_layout();
			// first two phases pin the stated range ends
			if (ph == 0)
				lay = '{mapping_mode: dam_pkg::MAP_MOP, mop_log2: 4'd12, permute_enable: 1'b1,
					channel_bits: 3'd4, bankgroup_bits: 3'd4, bank_bits: 3'd4,
					column_bits: 4'd14, cache_set_bits: 5'd24};
			else if (ph == 1)
				lay = '{mapping_mode: dam_pkg::MAP_ZEN, mop_log2: 4'd0, permute_enable: 1'b0,
					channel_bits: 3'd0, bankgroup_bits: 3'd0, bank_bits: 3'd0,
					column_bits: 4'd0, cache_set_bits: 5'd0};
			load_layout(lay);
			for (int k = 0; k < PHASE_REQS; k++)
				send($urandom_range(0, 1) ? dam_pkg::REQ_REWRITE : dam_pkg::REQ_DECODE,
					random_address(), 8'($urandom_range(0, 255)));
			drain();
		end

		if (errors == 0) begin
			$display("dram_address_mapper_core_tb: done, clean");
		end else begin
			$display("dram_address_mapper_core_tb: done, errors");
		end
		$finish;
	end

endmodule

FILE: sim.f
sv/dam_pkg.sv
sv/dam_req_if.sv
sv/dam_rsp_if.sv
sv/dam_cfg_regs.sv
sv/dam_map_logic.sv
sv/dram_address_mapper_core.sv
sv/dam_checker.sv
bench/dram_address_mapper_core_tb.sv
